// ===== hdl/stereo_channel_mixer_defines.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef STEREO_CHANNEL_MIXER_DEFINES_SVH
`define STEREO_CHANNEL_MIXER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SMX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stereo_channel_mixer assertion failed");
`define SMX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stereo_channel_mixer assertion failed");
`else
`define SMX_ASSERT_IMP(lbl, ante, cons)
`define SMX_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/smx_pkg.sv =====
package smx_pkg;

  localparam int CHANNELS = 16;
  localparam int PEAK_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W     = 4;
  localparam int SMP_W    = 16;
  localparam int RAW_W    = 7;
  localparam int COEF_W   = 8;
  localparam int DIV_W    = 2;
  localparam int SH_W     = 3;
  localparam int LEVEL_W  = 27;
  localparam int SUM_W    = 28;
  localparam int MA_W     = 28;
  localparam int MB_W     = 9;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int MIX_SH   = 10;
  localparam int MST_SH   = 15;
  localparam int FIN_W    = PROD_W - MST_SH;
  localparam int PEAK_W   = 15;
  localparam int PEAK_SH  = 11;
  localparam int OUT_W    = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam int CH_LO   = 0;
  localparam int SMP_LO  = CH_LO + CH_W;
  localparam int VOL_LO  = SMP_LO + SMP_W;
  localparam int DIV_LO  = VOL_LO + RAW_W;
  localparam int PAN_LO  = DIV_LO + DIV_W;

  localparam logic [PEAK_W-1:0]       PEAK_MAX  = 15'h7FFF;
  localparam logic signed [FIN_W-1:0] FIN_MAX   = FIN_W'(32'sh7FFF);
  localparam logic signed [FIN_W-1:0] FIN_MIN   = FIN_W'(-32'sh8000);
  localparam logic [OUT_W-1:0]        OUT_MAX   = 16'h7FFF;
  localparam logic [OUT_W-1:0]        OUT_MIN   = 16'h8000;
  localparam logic [OUT_W-1:0]        LOW_MASK  = 16'h003F;
  localparam logic [COEF_W-1:0]       COEF_FULL = 8'd128;
  localparam logic [RAW_W-1:0]        RAW_TOP   = 7'd127;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_LEVEL,
    ST_LEFT,
    ST_RIGHT,
    ST_MLEFT,
    ST_MRIGHT,
    ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LEVEL,
    MUL_LEFT,
    MUL_RIGHT,
    MUL_MLEFT,
    MUL_MRIGHT
  } mul_op_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ACCEPT,
    JC_NOTLAST
  } jump_t;

  typedef enum logic [1:0] {
    REG_MASTER_VOLUME,
    REG_MASTER_ENABLE,
    REG_TEN_BIT_OUTPUT
  } cfg_reg_t;

  typedef struct packed {
    mul_op_t op;
    logic    peak_upd;
    logic    emit;
    logic    in_rdy;
    jump_t   cond;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    ctrl_t word;
    logic  take;
    logic  emit_go;
  } dp_ctl_t;

  typedef struct packed {
    logic [RAW_W-1:0] master_volume;
    logic             master_enable;
    logic             ten_bit_output;
  } cfg_t;

  function automatic logic [COEF_W-1:0] widen7(input logic [RAW_W-1:0] raw);
    return (raw == RAW_TOP) ? COEF_FULL : {1'b0, raw};
  endfunction

  function automatic logic [SH_W-1:0] div_shift(input logic [DIV_W-1:0] sel);
    logic [SH_W-1:0] sh;
    case (sel)
      2'd0:    sh = 3'd4;
      2'd1:    sh = 3'd3;
      2'd2:    sh = 3'd2;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

// ===== hdl/smx_ucode_rom.sv =====
module smx_ucode_rom import smx_pkg::*; (
  input  step_t addr,
  output ctrl_t word
);

  always_comb begin
    word = '{op: MUL_NONE, peak_upd: 1'b0, emit: 1'b0, in_rdy: 1'b0,
             cond: JC_NEXT, target: ST_FETCH};
    case (addr)
      ST_FETCH: begin
        word.in_rdy = 1'b1;
        word.cond   = JC_ACCEPT;
        word.target = ST_LEVEL;
      end
      ST_LEVEL: begin
        word.op = MUL_LEVEL;
      end
      ST_LEFT: begin
        word.op       = MUL_LEFT;
        word.peak_upd = 1'b1;
      end
      ST_RIGHT: begin
        word.op     = MUL_RIGHT;
        word.cond   = JC_NOTLAST;
        word.target = ST_EMIT;
      end
      ST_MLEFT: begin
        word.op = MUL_MLEFT;
      end
      ST_MRIGHT: begin
        word.op = MUL_MRIGHT;
      end
      ST_EMIT: begin
        word.emit   = 1'b1;
        word.in_rdy = 1'b1;
        word.cond   = JC_ACCEPT;
        word.target = ST_LEVEL;
      end
      default: begin
        word.cond   = JC_ACCEPT;
        word.target = ST_FETCH;
      end
    endcase
  end

endmodule

// ===== hdl/smx_seq.sv =====
module smx_seq import smx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    out_free,
  input  logic    last,
  output logic    in_tready,
  output dp_ctl_t ctl
);

  step_t step_r;
  step_t step_nxt;
  ctrl_t word;
  logic  hold;
  logic  take;

  smx_ucode_rom u_rom (
    .addr (step_r),
    .word (word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    hold        = word.emit & ~out_free;
    in_tready   = word.in_rdy & ~hold;
    take        = in_tready & in_tvalid;
    ctl.word    = word;
    ctl.take    = take;
    ctl.emit_go = word.emit & out_free;
    case (word.cond)
      JC_NEXT: begin
        step_nxt = step_t'(step_r + 3'd1);
      end
      JC_ACCEPT: begin
        if (hold) begin
          step_nxt = step_r;
        end else if (take) begin
          step_nxt = word.target;
        end else if (word.emit) begin
          step_nxt = ST_FETCH;
        end else begin
          step_nxt = step_r;
        end
      end
      JC_NOTLAST: begin
        step_nxt = last ? step_t'(step_r + 3'd1) : word.target;
      end
      default: begin
        step_nxt = ST_FETCH;
      end
    endcase
  end

endmodule

// ===== hdl/smx_datapath.sv =====
module smx_datapath import smx_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_ctl_t                ctl,
  input  cfg_t                   cfg,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tready,
  output logic                   out_free,
  output logic                   last,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  logic [CH_W-1:0]          ch_r;
  logic signed [SMP_W-1:0]  smp_r;
  logic [COEF_W-1:0]        vol_r;
  logic [SH_W-1:0]          sh_r;
  logic [COEF_W-1:0]        pan_r;
  logic                     last_r;

  logic signed [LEVEL_W-1:0] level_r;
  logic signed [SUM_W-1:0]   left_sum_r;
  logic signed [SUM_W-1:0]   right_sum_r;
  logic [OUT_W-1:0]          fin_l_r;
  logic [OUT_W-1:0]          fin_r_r;
  logic [PEAK_W-1:0]         peak_r;
  logic [PEAK_W-1:0]         peak_q [CHANNELS];

  logic                     out_valid_r;
  logic                     out_user_r;
  logic [PEAK_W-1:0]        out_peak_r;
  logic [OUT_W-1:0]         out_left_r;
  logic [OUT_W-1:0]         out_right_r;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  mix_part;
  logic signed [FIN_W-1:0]  fin_raw;
  logic [OUT_W-1:0]         fin_clip;
  logic [OUT_W-1:0]         fin_val;
  logic [LEVEL_W-1:0]       lvl_abs;
  logic [OUT_W-1:0]         mag;
  logic [PEAK_W-1:0]        pk_new;
  logic [PEAK_W-1:0]        pk_old;
  logic [PEAK_W-1:0]        pk_upd;
  logic                     in_range;
  logic [PEAK_AW-1:0]       pk_idx;
  logic [COEF_W-1:0]        mv;

  assign mv       = widen7(cfg.master_volume);
  assign out_free = ~out_valid_r | out_tready;
  assign last     = last_r;

  always_comb begin
    case (ctl.word.op)
      MUL_LEVEL: begin
        mul_a = MA_W'(smp_r) <<< sh_r;
        mul_b = MB_W'(vol_r);
      end
      MUL_LEFT: begin
        mul_a = MA_W'(level_r);
        mul_b = MB_W'(COEF_FULL - pan_r);
      end
      MUL_RIGHT: begin
        mul_a = MA_W'(level_r);
        mul_b = MB_W'(pan_r);
      end
      MUL_MLEFT: begin
        mul_a = left_sum_r;
        mul_b = MB_W'(mv);
      end
      MUL_MRIGHT: begin
        mul_a = right_sum_r;
        mul_b = MB_W'(mv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign mix_part = SUM_W'(prod >>> MIX_SH);
  assign fin_raw  = prod[PROD_W-1:MST_SH];

  always_comb begin
    if (!cfg.master_enable) begin
      fin_clip = '0;
    end else if (fin_raw > FIN_MAX) begin
      fin_clip = OUT_MAX;
    end else if (fin_raw < FIN_MIN) begin
      fin_clip = OUT_MIN;
    end else begin
      fin_clip = fin_raw[OUT_W-1:0];
    end
    fin_val = cfg.ten_bit_output ? (fin_clip & ~LOW_MASK) : fin_clip;
  end

  always_comb begin
    lvl_abs  = level_r[LEVEL_W-1] ? LEVEL_W'(-level_r) : LEVEL_W'(level_r);
    mag      = lvl_abs[LEVEL_W-1:PEAK_SH];
    pk_new   = (mag > OUT_W'(PEAK_MAX)) ? PEAK_MAX : mag[PEAK_W-1:0];
    in_range = (32'(ch_r) < 32'(CHANNELS));
    pk_idx   = PEAK_AW'(ch_r);
    pk_old   = peak_q[pk_idx];
    pk_upd   = (in_range && (pk_old > pk_new)) ? pk_old : pk_new;
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      ch_r   <= in_tdata[CH_LO +: CH_W];
      smp_r  <= in_tdata[SMP_LO +: SMP_W];
      vol_r  <= widen7(in_tdata[VOL_LO +: RAW_W]);
      sh_r   <= div_shift(in_tdata[DIV_LO +: DIV_W]);
      pan_r  <= widen7(in_tdata[PAN_LO +: RAW_W]);
      last_r <= in_tlast;
    end
    if (ctl.word.op == MUL_LEVEL) begin
      level_r <= prod[LEVEL_W-1:0];
    end
    if (ctl.word.peak_upd) begin
      peak_r <= pk_upd;
    end
    if (ctl.word.op == MUL_MLEFT) begin
      fin_l_r <= fin_val;
    end
    if (ctl.word.op == MUL_MRIGHT) begin
      fin_r_r <= fin_val;
    end
    if (ctl.emit_go) begin
      out_peak_r  <= peak_r;
      out_user_r  <= last_r;
      out_left_r  <= last_r ? fin_l_r : '0;
      out_right_r <= last_r ? fin_r_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sum_r  <= '0;
      right_sum_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        peak_q[i] <= '0;
      end
    end else begin
      if (ctl.word.op == MUL_LEFT) begin
        left_sum_r <= left_sum_r + mix_part;
      end else if (ctl.emit_go && last_r) begin
        left_sum_r <= '0;
      end
      if (ctl.word.op == MUL_RIGHT) begin
        right_sum_r <= right_sum_r + mix_part;
      end else if (ctl.emit_go && last_r) begin
        right_sum_r <= '0;
      end
      if (ctl.word.peak_upd && in_range) begin
        peak_q[pk_idx] <= pk_upd;
      end
      if (ctl.emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = {1'b0, out_right_r, out_left_r, out_peak_r};

endmodule

// ===== hdl/stereo_channel_mixer.sv =====
// Channel   Ports                      Payload
// in        in_tvalid/in_tready        tdata: channel, sample, volume, divider, pan;
//                                      tlast: last_channel
// out       out_tvalid/out_tready      tdata: channel_peak, left_out, right_out;
//                                      tuser: frame_done
// cfg       cfg_psel/cfg_penable/...   master_volume @0, master_enable @4,
//                                      ten_bit_output @8
//
// A request steps through level, left, right and emit; one that closes a frame
// also passes master left and master right before emit. The one shared 28x9
// multiplier forms the level, both pan parts and both master-volume products in turn.
// Reset is synchronous and clears the peak meters, both accumulators, the step,
// the output valid flag and the config registers. The next request is taken
// in the cycle its predecessor's result is loaded into the output register, or
// later. While that register is held by a stall, one more request is taken and
// computed, and it then waits in its last step, where no request is taken.
`include "stereo_channel_mixer_defines.svh"

module stereo_channel_mixer import smx_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // channel[3:0], sample[19:4], volume[26:20], divider[28:27], pan[35:29]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // channel_peak[14:0], left_out[30:15], right_out[46:31]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // frame_done[0]
  output logic                   out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [3:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [RAW_W-1:0] master_volume_r;
  logic             master_enable_r;
  logic             ten_bit_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;
  cfg_t             cfg;
  dp_ctl_t          ctl;
  logic             out_free;
  logic             last;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_volume_r <= '0;
      master_enable_r <= 1'b0;
      ten_bit_r       <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_MASTER_VOLUME:  master_volume_r <= cfg_pwdata[RAW_W-1:0];
        REG_MASTER_ENABLE:  master_enable_r <= cfg_pwdata[0];
        REG_TEN_BIT_OUTPUT: ten_bit_r       <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_MASTER_VOLUME:  cfg_prdata = 32'(master_volume_r);
      REG_MASTER_ENABLE:  cfg_prdata = 32'(master_enable_r);
      REG_TEN_BIT_OUTPUT: cfg_prdata = 32'(ten_bit_r);
      default:            cfg_prdata = '0;
    endcase
  end

  assign cfg = '{master_volume: master_volume_r, master_enable: master_enable_r,
                 ten_bit_output: ten_bit_r};

  smx_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .out_free  (out_free),
    .last      (last),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  smx_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_free   (out_free),
    .last       (last),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `SMX_ASSERT_NXT(a_take_then_busy, in_tvalid && in_tready, !in_tready)
  `SMX_ASSERT_IMP(a_no_frame_zero, out_tvalid && !out_tuser, out_tdata[46:15] == 32'd0)
  `SMX_ASSERT_IMP(a_load_at_ready, $rose(out_tvalid), $past(in_tready))

endmodule
